>>> design/wmft_pkg.sv
// wmft_pkg: shared constants, codes and types of the window mode frequency tracker
// no dependencies; every other file of the block imports it
`timescale 1ns / 1ps

package wmft_pkg;

   // storage geometry
   localparam int DEPTH  = 1024;                // element positions
   localparam int VALUES = 1024;                // distinct element values
   localparam int POS_W  = $clog2(DEPTH);       // position / count-table index
   localparam int VAL_W  = $clog2(VALUES);      // element value
   localparam int CNT_W  = $clog2(DEPTH + 1);   // occurrence count, 0..DEPTH

   // request queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   // request command code
   localparam logic CMD_LOAD = 1'b0;

   // classified request kinds
   typedef enum logic [1:0] {
      OP_LOAD,
      OP_QUERY,
      OP_BAD
   } op_type;

   // one classified request as it travels from front to back
   typedef struct packed {
      op_type             kind;
      logic [POS_W-1:0]   position;
      logic [VAL_W-1:0]   value;
      logic [POS_W-1:0]   first;    // first position of the range
      logic [CNT_W-1:0]   stop;     // last position plus one
      logic [CNT_W-1:0]   length;   // stop - first
   } entry_type;

   // back-end sequencer states
   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_PICK,
      ST_VALUE,
      ST_COUNT,
      ST_OLD,
      ST_NEW,
      ST_STORE,
      ST_RESULT
   } back_state_type;

endpackage

>>> design/wmft_if.sv
// wmft_if: valid/ready channel interfaces for requests and responses
// depends on wmft_pkg for field widths
`timescale 1ns / 1ps

interface wmft_req_if import wmft_pkg::*; ();
   logic             valid;
   logic             ready;
   logic             cmd;
   logic [POS_W-1:0] position;
   logic [VAL_W-1:0] value;
   logic [POS_W-1:0] range_first;
   logic [POS_W-1:0] range_last;

   modport source (output valid, cmd, position, value, range_first, range_last,
                   input ready);
   modport sink   (input valid, cmd, position, value, range_first, range_last,
                   output ready);
endinterface

interface wmft_rsp_if import wmft_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [CNT_W-1:0] max_count;
   logic [CNT_W-1:0] range_length;
   logic             bad_range;

   modport source (output valid, max_count, range_length, bad_range, input ready);
   modport sink   (input valid, max_count, range_length, bad_range, output ready);
endinterface

>>> design/window_mode_frequency_tracker_top.sv
// window_mode_frequency_tracker_top: range mode frequency over a loadable element array
// a request walks the window over each element it passes, with a read-modify-write of the count
// and count-of-counts memories that skips a table step when that element's old or new count is
// zero; an inverted range answers without moving the window; a load drains its window the same
// way and then writes the element, leaving the window empty
// throughput: one request at a time in the back end; a 2-entry queue plus front register buffer
// reset: synchronous; a clearing pass then zeroes the count tables, taking no request meanwhile
`timescale 1ns / 1ps

module window_mode_frequency_tracker_top import wmft_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   wmft_req_if.sink    req_chan,
   wmft_rsp_if.source  rsp_chan
);

   logic      clearing;
   logic      push_valid, push_ready;
   entry_type push_data;
   logic      pop_valid, pop_ready;
   entry_type pop_data;

   // accept and classify
   wmft_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .clearing   (clearing),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   // decouple front from back
   wmft_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   // move the window and answer
   wmft_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_valid  (pop_valid),
      .q_ready  (pop_ready),
      .q_data   (pop_data),
      .clearing (clearing),
      .rsp_chan (rsp_chan)
   );

endmodule

>>> design/wmft_front.sv
// wmft_front: accepts requests, classifies them and hands them to the queue
// depends on wmft_pkg and wmft_req_if
`timescale 1ns / 1ps

module wmft_front import wmft_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   wmft_req_if.sink    req_chan,
   input  logic        clearing,
   output logic        push_valid,
   input  logic        push_ready,
   output entry_type   push_data
);

   logic      hold_valid_ff, hold_valid_in;
   entry_type hold_ff, hold_in;
   logic      take;

   // no request is taken while the count tables are being cleared
   assign req_chan.ready = !clearing && (!hold_valid_ff || push_ready);
   assign take           = req_chan.valid && req_chan.ready;

   // classify the request and precompute the range bounds
   always_comb begin
      hold_in          = hold_ff;
      hold_valid_in    = hold_valid_ff && !push_ready;
      if (take) begin
         hold_valid_in     = 1'b1;
         hold_in.position  = req_chan.position;
         hold_in.value     = req_chan.value;
         hold_in.first     = req_chan.range_first;
         hold_in.stop      = {1'b0, req_chan.range_last} + CNT_W'(1);
         hold_in.length    = hold_in.stop - {1'b0, req_chan.range_first};
         if (req_chan.cmd == CMD_LOAD) begin
            hold_in.kind = OP_LOAD;
         end else if (req_chan.range_first > req_chan.range_last) begin
            hold_in.kind = OP_BAD;
         end else begin
            hold_in.kind = OP_QUERY;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_ff <= hold_in;
   end

   assign push_valid = hold_valid_ff;
   assign push_data  = hold_ff;

endmodule

>>> design/wmft_queue.sv
// wmft_queue: short request queue between the front and the back end
// depends on wmft_pkg
`timescale 1ns / 1ps

module wmft_queue import wmft_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        push_valid,
   output logic        push_ready,
   input  entry_type   push_data,
   output logic        pop_valid,
   input  logic        pop_ready,
   output entry_type   pop_data
);

   entry_type         slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W:0]   fill_ff, fill_in;
   logic              do_push, do_pop;

   assign push_ready = (fill_ff != (QPTR_W + 1)'(QUEUE_DEPTH));
   assign pop_valid  = (fill_ff != '0);
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // pointer and fill bookkeeping
   always_comb begin
      rd_ptr_in = do_pop  ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      wr_ptr_in = do_push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      fill_in   = fill_ff;
      if (do_push && !do_pop) begin
         fill_in = fill_ff + (QPTR_W + 1)'(1);
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - (QPTR_W + 1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> design/wmft_back.sv
// wmft_back: window sequencer with element store, count and count-of-counts memories
// depends on wmft_pkg and wmft_rsp_if; drives the response register
`timescale 1ns / 1ps

module wmft_back import wmft_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        q_valid,
   output logic        q_ready,
   input  entry_type   q_data,
   output logic        clearing,
   wmft_rsp_if.source  rsp_chan
);

   back_state_type   state_ff, state_in;
   logic [POS_W-1:0] clr_idx_ff, clr_idx_in;
   entry_type        cur_ff, cur_in;
   logic [POS_W-1:0] win_start_ff, win_start_in;
   logic [CNT_W-1:0] win_end_ff, win_end_in;
   logic [CNT_W-1:0] highest_ff, highest_in;
   logic             add_ff, add_in;
   logic [VAL_W-1:0] val_ff, val_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             out_valid_ff, out_valid_in;
   logic [CNT_W-1:0] out_max_ff, out_max_in;
   logic [CNT_W-1:0] out_len_ff, out_len_in;
   logic             out_bad_ff, out_bad_in;

   // memory ports
   logic [VAL_W-1:0] elem_mem [DEPTH];
   logic             elem_we;
   logic [POS_W-1:0] elem_waddr, elem_raddr;
   logic [VAL_W-1:0] elem_wdata, elem_rd_ff;
   logic [CNT_W-1:0] cnt_mem [VALUES];
   logic             cnt_we;
   logic [VAL_W-1:0] cnt_waddr, cnt_raddr;
   logic [CNT_W-1:0] cnt_wdata, cnt_rd_ff;
   logic [CNT_W-1:0] tbl_mem [DEPTH];   // entry k holds how many values have count k+1
   logic             tbl_we;
   logic [POS_W-1:0] tbl_waddr, tbl_raddr;
   logic [CNT_W-1:0] tbl_wdata, tbl_rd_ff;

   // window move decode
   logic [CNT_W-1:0] start_ext;
   logic             grow_left, grow_right, shrink_left, shrink_right, drain;
   logic             move_any, pick_add;
   logic [POS_W-1:0] pick_pos;
   logic [POS_W-1:0] pick_start;
   logic [CNT_W-1:0] pick_end;
   logic [CNT_W-1:0] read_step, held_step;
   logic             out_free;

   assign start_ext    = {1'b0, win_start_ff};
   assign grow_left    = win_start_ff > cur_ff.first;
   assign grow_right   = win_end_ff < cur_ff.stop;
   assign shrink_left  = win_start_ff < cur_ff.first;
   assign shrink_right = win_end_ff > cur_ff.stop;
   assign drain        = win_end_ff > start_ext;
   assign out_free     = !out_valid_ff || rsp_chan.ready;

   // new count after the step, from the fresh read and from the held copy
   assign read_step = add_ff ? cnt_rd_ff + CNT_W'(1) : cnt_rd_ff - CNT_W'(1);
   assign held_step = add_ff ? cnt_ff + CNT_W'(1) : cnt_ff - CNT_W'(1);

   // pick the next element to move: grow left, grow right, shrink left, shrink right;
   // a load drains the window from the right end
   always_comb begin
      pick_add   = 1'b0;
      pick_pos   = win_start_ff;
      pick_start = win_start_ff;
      pick_end   = win_end_ff;
      move_any   = 1'b1;
      if (cur_ff.kind == OP_LOAD) begin
         if (drain) begin
            pick_end = win_end_ff - CNT_W'(1);
            pick_pos = pick_end[POS_W-1:0];
         end else begin
            move_any = 1'b0;
         end
      end else if (grow_left) begin
         pick_add   = 1'b1;
         pick_start = win_start_ff - POS_W'(1);
         pick_pos   = pick_start;
      end else if (grow_right) begin
         pick_add = 1'b1;
         pick_pos = win_end_ff[POS_W-1:0];
         pick_end = win_end_ff + CNT_W'(1);
      end else if (shrink_left) begin
         pick_pos   = win_start_ff;
         pick_start = win_start_ff + POS_W'(1);
      end else if (shrink_right) begin
         pick_end = win_end_ff - CNT_W'(1);
         pick_pos = pick_end[POS_W-1:0];
      end else begin
         move_any = 1'b0;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_idx_ff == POS_W'(DEPTH - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (q_valid) begin
               state_in = (q_data.kind == OP_BAD) ? ST_RESULT : ST_PICK;
            end
         end
         ST_PICK: begin
            if (move_any) begin
               state_in = ST_VALUE;
            end else if (cur_ff.kind == OP_LOAD) begin
               state_in = ST_STORE;
            end else begin
               state_in = ST_RESULT;
            end
         end
         ST_VALUE: state_in = ST_COUNT;
         ST_COUNT: begin
            if (cnt_rd_ff != '0) begin
               state_in = ST_OLD;
            end else if (add_ff) begin
               state_in = ST_NEW;
            end else begin
               state_in = ST_PICK;
            end
         end
         ST_OLD: state_in = (held_step != '0) ? ST_NEW : ST_PICK;
         ST_NEW: state_in = ST_PICK;
         ST_STORE: state_in = ST_IDLE;
         ST_RESULT: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath, memory controls and response register
   always_comb begin
      clr_idx_in   = clr_idx_ff;
      cur_in       = cur_ff;
      win_start_in = win_start_ff;
      win_end_in   = win_end_ff;
      highest_in   = highest_ff;
      add_in       = add_ff;
      val_in       = val_ff;
      cnt_in       = cnt_ff;
      out_valid_in = out_valid_ff && !rsp_chan.ready;
      out_max_in   = out_max_ff;
      out_len_in   = out_len_ff;
      out_bad_in   = out_bad_ff;
      q_ready      = 1'b0;
      elem_we      = 1'b0;
      elem_waddr   = cur_ff.position;
      elem_wdata   = cur_ff.value;
      elem_raddr   = pick_pos;
      cnt_we       = 1'b0;
      cnt_waddr    = val_ff;
      cnt_wdata    = read_step;
      cnt_raddr    = elem_rd_ff;
      tbl_we       = 1'b0;
      tbl_waddr    = POS_W'(cnt_ff - CNT_W'(1));
      tbl_wdata    = tbl_rd_ff - CNT_W'(1);
      tbl_raddr    = POS_W'(cnt_rd_ff - CNT_W'(1));
      case (state_ff)
         // zero both count tables, one entry of each per cycle
         ST_CLEAR: begin
            cnt_we     = 1'b1;
            cnt_waddr  = VAL_W'(clr_idx_ff);
            cnt_wdata  = '0;
            tbl_we     = 1'b1;
            tbl_waddr  = clr_idx_ff;
            tbl_wdata  = '0;
            clr_idx_in = clr_idx_ff + POS_W'(1);
         end
         // take the next request; for a query, an empty window moves to the range start
         ST_IDLE: begin
            q_ready = 1'b1;
            if (q_valid) begin
               cur_in = q_data;
               if (q_data.kind == OP_QUERY && start_ext >= win_end_ff) begin
                  win_start_in = q_data.first;
                  win_end_in   = {1'b0, q_data.first};
               end
            end
         end
         // step a pointer and fetch the element it passes
         ST_PICK: begin
            win_start_in = pick_start;
            win_end_in   = pick_end;
            add_in       = pick_add;
         end
         // element value known: fetch its count
         ST_VALUE: begin
            val_in = elem_rd_ff;
         end
         // count known: write the new count, fetch the old count's table entry
         ST_COUNT: begin
            cnt_in = cnt_rd_ff;
            cnt_we = add_ff || (cnt_rd_ff != '0);
            if (add_ff && cnt_rd_ff == highest_ff) highest_in = highest_ff + CNT_W'(1);
            if (cnt_rd_ff == '0) tbl_raddr = '0;
         end
         // one value fewer at the old count; fetch the new count's entry
         ST_OLD: begin
            tbl_we    = 1'b1;
            tbl_raddr = POS_W'(held_step - CNT_W'(1));
            if (!add_ff && cnt_ff == highest_ff && tbl_rd_ff == CNT_W'(1)) begin
               highest_in = highest_ff - CNT_W'(1);
            end
         end
         // one value more at the new count
         ST_NEW: begin
            tbl_we    = 1'b1;
            tbl_waddr = POS_W'(held_step - CNT_W'(1));
            tbl_wdata = tbl_rd_ff + CNT_W'(1);
         end
         // window is empty now: write the loaded element
         ST_STORE: begin
            elem_we      = 1'b1;
            win_start_in = '0;
            win_end_in   = '0;
            highest_in   = '0;
         end
         // hand the result to the response register
         ST_RESULT: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               if (cur_ff.kind == OP_BAD) begin
                  out_max_in = '0;
                  out_len_in = '0;
                  out_bad_in = 1'b1;
               end else begin
                  out_max_in = highest_ff;
                  out_len_in = cur_ff.length;
                  out_bad_in = 1'b0;
               end
            end
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_idx_ff   <= '0;
         win_start_ff <= '0;
         win_end_ff   <= '0;
         highest_ff   <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_idx_ff   <= clr_idx_in;
         win_start_ff <= win_start_in;
         win_end_ff   <= win_end_in;
         highest_ff   <= highest_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cur_ff     <= cur_in;
      add_ff     <= add_in;
      val_ff     <= val_in;
      cnt_ff     <= cnt_in;
      out_max_ff <= out_max_in;
      out_len_ff <= out_len_in;
      out_bad_ff <= out_bad_in;
   end

   // element store
   always_ff @(posedge clock) begin
      if (elem_we) elem_mem[elem_waddr] <= elem_wdata;
      elem_rd_ff <= elem_mem[elem_raddr];
   end

   // per-value counts
   always_ff @(posedge clock) begin
      if (cnt_we) cnt_mem[cnt_waddr] <= cnt_wdata;
      cnt_rd_ff <= cnt_mem[cnt_raddr];
   end

   // count-of-counts table
   always_ff @(posedge clock) begin
      if (tbl_we) tbl_mem[tbl_waddr] <= tbl_wdata;
      tbl_rd_ff <= tbl_mem[tbl_raddr];
   end

   assign clearing              = (state_ff == ST_CLEAR);
   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.max_count    = out_max_ff;
   assign rsp_chan.range_length = out_len_ff;
   assign rsp_chan.bad_range    = out_bad_ff;

endmodule
